/* sv/ptd_pkg.sv */
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants of the priority task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int NUM_PRIO  = 4;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int PRIO_W    = 2;
    localparam int TOTAL_W   = 5;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_ADD_PER  = 3'd1;
    localparam logic [2:0] CMD_ADD_ONE  = 3'd2;
    localparam logic [2:0] CMD_ENABLE   = 3'd3;
    localparam logic [2:0] CMD_DISABLE  = 3'd4;
    localparam logic [2:0] CMD_REMOVE   = 3'd5;
    localparam logic [2:0] CMD_RST_DLY  = 3'd6;
    localparam logic [2:0] CMD_RUN      = 3'd7;

    localparam logic [1:0] KIND_ACK      = 2'd0;
    localparam logic [1:0] KIND_REJECT   = 2'd1;
    localparam logic [1:0] KIND_DISPATCH = 2'd2;
    localparam logic [1:0] KIND_NONE_DUE = 2'd3;

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_READY    = 2'd1;
    localparam logic [1:0] MODE_DISABLED = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  slot;
        logic [31:0] time_value;
        logic [1:0]  task_priority;
        logic [15:0] task_tag;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  out_slot;
        logic [15:0] out_tag;
        logic        last;
        logic [31:0] tick_now;
        logic [4:0]  active_tasks;
    } t_out_word;

    // broadcast to every cell
    typedef struct packed {
        logic              tick;
        logic              enable;
        logic              disable_t;
        logic              remove;
        logic              rst_delay;
        logic              add;
        logic              periodic;
        logic [31:0]       time_value;
        logic [PRIO_W-1:0] prio;
        logic [15:0]       tag;
    } t_cell_cmd;

    typedef struct packed {
        logic [1:0]        mode;
        logic              periodic;
        logic              delay_zero;
        logic [PRIO_W-1:0] prio;
        logic [15:0]       tag;
    } t_cell_stat;

endpackage

/* sv/ptd_cell.sv */
// ----------------------------------------------------------------------------
// ptd_cell
// One task slot; passes the free-slot claim to its right-hand neighbor.
// ----------------------------------------------------------------------------
module ptd_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptd_pkg::t_cell_cmd i_cmd,
    input  logic               i_sel,
    input  logic               i_dispatch,
    input  logic               i_claim,
    output logic               o_claim,
    output logic               o_take,
    output ptd_pkg::t_cell_stat o_stat
);
    import ptd_pkg::*;

    logic [1:0]        r_mode;
    logic              r_periodic;
    logic [31:0]       r_period;
    logic [31:0]       r_delay;
    logic [PRIO_W-1:0] r_prio;
    logic [15:0]       r_tag;
    logic              idle;

    assign idle    = (r_mode == MODE_IDLE);
    assign o_take  = i_claim && idle;
    assign o_claim = i_claim && !idle;

    assign o_stat.mode       = r_mode;
    assign o_stat.periodic   = r_periodic;
    assign o_stat.delay_zero = (r_delay == 32'd0);
    assign o_stat.prio       = r_prio;
    assign o_stat.tag        = r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
        end else if (i_cmd.add && o_take) begin
            r_mode     <= MODE_READY;
            r_periodic <= i_cmd.periodic;
            r_period   <= i_cmd.periodic ? i_cmd.time_value : 32'd0;
            r_delay    <= i_cmd.time_value;
            r_prio     <= i_cmd.prio;
            r_tag      <= i_cmd.tag;
        end else if (i_cmd.tick) begin
            if (r_mode == MODE_READY && r_delay != 32'd0) begin
                r_delay <= r_delay - 32'd1;
            end
        end else if (i_sel && i_cmd.remove) begin
            r_mode     <= MODE_IDLE;
            r_periodic <= 1'b0;
            r_period   <= 32'd0;
            r_delay    <= 32'd0;
            r_prio     <= '0;
            r_tag      <= 16'd0;
        end else if (i_sel && !idle && i_cmd.enable) begin
            r_mode <= MODE_READY;
        end else if (i_sel && !idle && i_cmd.disable_t) begin
            r_mode <= MODE_DISABLED;
        end else if (i_sel && !idle && i_cmd.rst_delay) begin
            r_mode  <= MODE_READY;
            r_delay <= (r_period != 32'd0) ? r_period : 32'd1;
        end else if (i_dispatch) begin
            if (r_periodic) begin
                r_delay <= r_period;
            end else begin
                r_mode <= MODE_IDLE;
                r_tag  <= 16'd0;
            end
        end
    end

endmodule

/* sv/priority_task_dispatcher_unit.sv */
// ----------------------------------------------------------------------------
// priority_task_dispatcher_unit
// Cooperative priority task table built from a chain of slot cells.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one command word:
// tick, add periodic, add one-shot, enable, disable, remove, reset delay, run.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns result words;
// the final word of a command has last set.
// Every command but run gives one word, registered in the cycle after acceptance.
// A run walks priority 0..3 and slot 0..15, one slot per cycle while the
// output is not stalled, ends after the last due slot, and gives one word
// per due slot, or one "nothing due" word.
// One command is in flight at a time: o_in_ready is high only when the
// controller is idle and the output register is empty.
// A stalled receiver holds the output register and freezes the run scan.
// Reset (synchronous, active low) empties the table, clears the tick counter
// and task count and drops o_out_valid; the block is ready the next cycle.
// ----------------------------------------------------------------------------
module priority_task_dispatcher_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ptd_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ptd_pkg::t_out_word o_out_data
);
    import ptd_pkg::*;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state             r_state;
    logic [SLOT_W-1:0]  r_i;
    logic [PRIO_W-1:0]  r_p;
    logic               r_found;
    logic [31:0]        r_tick;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic               r_out_valid;
    t_out_word          r_out;

    t_cell_cmd          cmd;
    t_cell_stat         stat [NUM_SLOTS];
    logic [NUM_SLOTS:0] claim;
    logic [NUM_SLOTS-1:0] take, sel, disp;
    logic [SLOT_W-1:0]  add_idx;
    logic               acc, can_emit, add_ok, sel_busy;
    logic               cur_due, more_due, end_of_scan;
    logic               out_load;
    t_cell_stat         cur;
    logic [2:0]         c;

    assign acc      = i_in_valid && o_in_ready;
    assign can_emit = !r_out_valid || i_out_ready;
    assign c        = i_in_data.command;

    always_comb begin
        cmd.tick       = acc && (c == CMD_TICK);
        cmd.enable     = acc && (c == CMD_ENABLE);
        cmd.disable_t  = acc && (c == CMD_DISABLE);
        cmd.remove     = acc && (c == CMD_REMOVE);
        cmd.rst_delay  = acc && (c == CMD_RST_DLY);
        cmd.periodic   = (c == CMD_ADD_PER);
        cmd.add        = acc && ((c == CMD_ADD_ONE) ||
                         ((c == CMD_ADD_PER) && (i_in_data.time_value != 32'd0)));
        cmd.time_value = i_in_data.time_value;
        cmd.prio       = (int'(i_in_data.task_priority) >= NUM_PRIO)
                         ? PRIO_W'(NUM_PRIO - 1) : i_in_data.task_priority;
        cmd.tag        = i_in_data.task_tag;
    end

    assign claim[0] = 1'b1;

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
            assign sel[g]  = (i_in_data.slot == 4'(g));
            assign disp[g] = (r_state == S_RUN) && can_emit && cur_due && (r_i == SLOT_W'(g));
            ptd_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (cmd),
                .i_sel      (sel[g]),
                .i_dispatch (disp[g]),
                .i_claim    (claim[g]),
                .o_claim    (claim[g+1]),
                .o_take     (take[g]),
                .o_stat     (stat[g])
            );
        end
    endgenerate

    // one-hot free slot to index; also selected-slot busy and any later due slot
    always_comb begin
        add_idx  = '0;
        sel_busy = 1'b0;
        more_due = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (take[k]) add_idx = add_idx | SLOT_W'(k);
            if (sel[k] && stat[k].mode != MODE_IDLE) sel_busy = 1'b1;
            if (stat[k].mode == MODE_READY && stat[k].delay_zero &&
                ((stat[k].prio > r_p) ||
                 (stat[k].prio == r_p && SLOT_W'(k) > r_i))) more_due = 1'b1;
        end
    end

    assign add_ok      = cmd.add && !claim[NUM_SLOTS];
    assign cur         = stat[r_i];
    assign cur_due     = (cur.mode == MODE_READY) && cur.delay_zero && (cur.prio == r_p);
    assign end_of_scan = (r_i == SLOT_W'(NUM_SLOTS - 1)) && (r_p == PRIO_W'(NUM_PRIO - 1));

    // a word enters the output register this cycle
    assign out_load = (acc && (c != CMD_RUN)) ||
                      ((r_state == S_RUN) && can_emit &&
                       (cur_due || (end_of_scan && !r_found)));

    always_comb begin
        n_total = r_total;
        if (add_ok) begin
            n_total = r_total + TOTAL_W'(1);
        end else if (cmd.remove && sel_busy) begin
            n_total = r_total - TOTAL_W'(1);
        end else if ((r_state == S_RUN) && can_emit && cur_due && !cur.periodic) begin
            n_total = r_total - TOTAL_W'(1);
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tick      <= 32'd0;
            r_total     <= '0;
            r_i         <= '0;
            r_p         <= '0;
            r_found     <= 1'b0;
        end else begin
            r_total <= n_total;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_out.out_slot     <= add_ok ? 4'(add_idx) : 4'd0;
                        r_out.out_tag      <= 16'd0;
                        r_out.last         <= 1'b1;
                        r_out.active_tasks <= n_total;
                        r_out.kind         <= ((c == CMD_ADD_PER || c == CMD_ADD_ONE) &&
                                               !add_ok) ? KIND_REJECT : KIND_ACK;
                        r_out.tick_now     <= (c == CMD_TICK) ? r_tick + 32'd1 : r_tick;
                        if (c == CMD_RUN) begin
                            r_state <= S_RUN;
                            r_i     <= '0;
                            r_p     <= '0;
                            r_found <= 1'b0;
                        end else if (c == CMD_TICK) begin
                            r_tick <= r_tick + 32'd1;
                        end
                    end
                end
                S_RUN: begin
                    if (can_emit) begin
                        if (cur_due) begin
                            r_out.kind         <= KIND_DISPATCH;
                            r_out.out_slot     <= 4'(r_i);
                            r_out.out_tag      <= cur.tag;
                            r_out.last         <= !more_due;
                            r_out.tick_now     <= r_tick;
                            r_out.active_tasks <= n_total;
                            r_found            <= 1'b1;
                        end
                        if (cur_due && !more_due) begin
                            r_state <= S_IDLE;
                        end else if (end_of_scan) begin
                            r_state <= S_IDLE;
                            if (!r_found && !cur_due) begin
                                r_out.kind         <= KIND_NONE_DUE;
                                r_out.out_slot     <= 4'd0;
                                r_out.out_tag      <= 16'd0;
                                r_out.last         <= 1'b1;
                                r_out.tick_now     <= r_tick;
                                r_out.active_tasks <= n_total;
                            end
                        end else if (r_i == SLOT_W'(NUM_SLOTS - 1)) begin
                            r_i <= '0;
                            r_p <= r_p + PRIO_W'(1);
                        end else begin
                            r_i <= r_i + SLOT_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/ptd_checker.sv */
// ----------------------------------------------------------------------------
// ptd_checker
// Port-level checks of the priority task dispatcher.
// ----------------------------------------------------------------------------
module ptd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input ptd_pkg::t_in_word  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ptd_pkg::t_out_word o_out_data
);
    import ptd_pkg::*;

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    // only one command in flight
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second command taken too early");

    // tag only on dispatch words
    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_DISPATCH |-> o_out_data.out_tag == 16'd0)
        else $error("tag on non-dispatch word");

    // a non-run command gives its word the next cycle
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.command != CMD_RUN |=>
            o_out_valid && o_out_data.last)
        else $error("missing result word");

endmodule

bind priority_task_dispatcher_unit ptd_checker u_ptd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Checks the priority task dispatcher against a cycle-free model of its task
// table, with random source bursts and random sink stalls.
// ----------------------------------------------------------------------------
module tb;
    import ptd_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_data;

    priority_task_dispatcher_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // model of the task table
    logic [1:0]  tbl_mode   [NUM_SLOTS];
    logic        tbl_per    [NUM_SLOTS];
    logic [31:0] tbl_period [NUM_SLOTS];
    logic [31:0] tbl_delay  [NUM_SLOTS];
    logic [1:0]  tbl_prio   [NUM_SLOTS];
    logic [15:0] tbl_tag    [NUM_SLOTS];
    logic [31:0] tick_cnt;
    logic [4:0]  live_cnt;

    t_out_word   pending_words[$];
    int          mismatches;
    int          words_seen;
    int          sent_items;
    int          dispatches_seen;
    int          burst_left;
    bit          sink_busy;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("timeout with %0d words pending", pending_words.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void clear_entry(int i);
        tbl_mode[i]   = MODE_IDLE;
        tbl_per[i]    = 1'b0;
        tbl_period[i] = '0;
        tbl_delay[i]  = '0;
        tbl_prio[i]   = '0;
        tbl_tag[i]    = '0;
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < NUM_SLOTS; i++) clear_entry(i);
        tick_cnt = '0;
        live_cnt = '0;
    endfunction

    function automatic void push_word(logic [1:0] k, logic [3:0] s, logic [15:0] t);
        t_out_word w;
        w.kind = k;
        w.out_slot = s;
        w.out_tag = t;
        w.last = 1'b0;
        w.tick_now = tick_cnt;
        w.active_tasks = live_cnt;
        pending_words.push_back(w);
    endfunction

    // updates the table for one command and queues the words it yields
    function automatic void predict_command(t_in_word c);
        int s;
        int found;
        int cnt;
        logic [15:0] t;
        s = c.slot;
        cnt = 0;
        case (c.command)
            CMD_TICK: begin
                tick_cnt++;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (tbl_mode[i] == MODE_READY && tbl_delay[i] != 0) tbl_delay[i]--;
                push_word(KIND_ACK, 0, 0);
            end
            CMD_ADD_PER, CMD_ADD_ONE: begin
                found = -1;
                if (!(c.command == CMD_ADD_PER && c.time_value == 0))
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (found < 0 && tbl_mode[i] == MODE_IDLE) found = i;
                if (found < 0) begin
                    push_word(KIND_REJECT, 0, 0);
                end else begin
                    tbl_mode[found]   = MODE_READY;
                    tbl_per[found]    = (c.command == CMD_ADD_PER);
                    tbl_period[found] = (c.command == CMD_ADD_PER) ? c.time_value : 0;
                    tbl_delay[found]  = c.time_value;
                    tbl_prio[found]   = c.task_priority;
                    tbl_tag[found]    = c.task_tag;
                    live_cnt++;
                    push_word(KIND_ACK, found[3:0], 0);
                end
            end
            CMD_ENABLE, CMD_DISABLE: begin
                if (tbl_mode[s] != MODE_IDLE)
                    tbl_mode[s] = (c.command == CMD_ENABLE) ? MODE_READY : MODE_DISABLED;
                push_word(KIND_ACK, 0, 0);
            end
            CMD_REMOVE: begin
                if (tbl_mode[s] != MODE_IDLE) live_cnt--;
                clear_entry(s);
                push_word(KIND_ACK, 0, 0);
            end
            CMD_RST_DLY: begin
                if (tbl_mode[s] != MODE_IDLE) begin
                    tbl_delay[s] = (tbl_period[s] != 0) ? tbl_period[s] : 32'd1;
                    tbl_mode[s]  = MODE_READY;
                end
                push_word(KIND_ACK, 0, 0);
            end
            default: begin
                for (int p = 0; p < NUM_PRIO; p++)
                    for (int i = 0; i < NUM_SLOTS; i++)
                        if (cnt < 16 && tbl_mode[i] == MODE_READY && tbl_prio[i] == p
                                && tbl_delay[i] == 0) begin
                            t = tbl_tag[i];
                            if (tbl_per[i]) begin
                                tbl_delay[i] = tbl_period[i];
                            end else begin
                                clear_entry(i);
                                live_cnt--;
                            end
                            push_word(KIND_DISPATCH, i[3:0], t);
                            cnt++;
                        end
                if (cnt == 0) push_word(KIND_NONE_DUE, 0, 0);
            end
        endcase
        pending_words[$].last = 1'b1;
    endfunction

    // sink: stalls on its own pattern and checks each word
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", out_data);
            end else begin
                if (out_data !== pending_words[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: expected %p, got %p",
                                 pending_words[0], out_data);
                end
                if (out_data.kind == KIND_DISPATCH) dispatches_seen++;
                void'(pending_words.pop_front());
            end
        end
    end

    always @(negedge clk) begin
        if (sink_busy) out_ready <= ($urandom_range(0, 3) != 0);
        else out_ready <= 1'b1;
    end

    initial begin
        sink_busy = 1'b1;
        forever begin
            repeat ($urandom_range(50, 400)) @(posedge clk);
            sink_busy = ~sink_busy;
        end
    end

    task automatic send_word(t_in_word c);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_data  = c;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_command(c);
        sent_items++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic t_in_word make_cmd(logic [2:0] op, logic [3:0] s,
                                          logic [31:0] tv, logic [1:0] pr,
                                          logic [15:0] tg);
        t_in_word c;
        c.command = op;
        c.slot = s;
        c.time_value = tv;
        c.task_priority = pr;
        c.task_tag = tg;
        return c;
    endfunction

    task automatic drain();
        while (pending_words.size() != 0) @(negedge clk);
    endtask

    task automatic test_directed();
        send_word(make_cmd(CMD_RUN, 0, 0, 0, 0));
        send_word(make_cmd(CMD_ADD_PER, 0, 0, 0, 16'h1111));
        send_word(make_cmd(CMD_ADD_ONE, 0, 0, 3, 16'hFFFF));
        send_word(make_cmd(CMD_ADD_PER, 0, 1, 1, 16'h0000));
        send_word(make_cmd(CMD_ADD_PER, 0, 32'hFFFF_FFFF, 2, 16'hA5A5));
        send_word(make_cmd(CMD_ADD_ONE, 0, 2, 0, 16'h5A5A));
        send_word(make_cmd(CMD_RUN, 0, 0, 0, 0));
        send_word(make_cmd(CMD_TICK, 0, 0, 0, 0));
        send_word(make_cmd(CMD_DISABLE, 1, 0, 0, 0));
        send_word(make_cmd(CMD_TICK, 0, 0, 0, 0));
        send_word(make_cmd(CMD_RUN, 0, 0, 0, 0));
        send_word(make_cmd(CMD_ENABLE, 1, 0, 0, 0));
        send_word(make_cmd(CMD_RST_DLY, 2, 0, 0, 0));
        send_word(make_cmd(CMD_RST_DLY, 15, 0, 0, 0));
        send_word(make_cmd(CMD_ENABLE, 14, 0, 0, 0));
        send_word(make_cmd(CMD_REMOVE, 13, 0, 0, 0));
        send_word(make_cmd(CMD_TICK, 0, 0, 0, 0));
        send_word(make_cmd(CMD_RUN, 0, 0, 0, 0));
        send_word(make_cmd(CMD_REMOVE, 2, 0, 0, 0));
        send_word(make_cmd(CMD_REMOVE, 1, 0, 0, 0));
        drain();
    endtask

    // fill the table, reject on full, then dispatch all sixteen in one run
    task automatic test_full_table();
        for (int i = 0; i < 17; i++)
            send_word(make_cmd(CMD_ADD_ONE, 0, 0, 2'($urandom_range(0, 3)),
                               16'($urandom)));
        send_word(make_cmd(CMD_RUN, 0, 0, 0, 0));
        drain();
    endtask

    task automatic test_random();
        t_in_word c;
        int pick;
        for (int n = 0; n < 180; n++) begin
            pick = $urandom_range(0, 99);
            c.slot = 4'($urandom);
            c.task_priority = 2'($urandom);
            c.task_tag = 16'($urandom);
            c.time_value = $urandom;
            if (pick < 25) c.command = CMD_TICK;
            else if (pick < 45) c.command = CMD_RUN;
            else if (pick < 65) c.command = ($urandom_range(0, 1) != 0) ? CMD_ADD_PER : CMD_ADD_ONE;
            else c.command = 3'($urandom_range(3, 6));
            if (pick < 62 && $urandom_range(0, 9) != 0) c.time_value = $urandom_range(0, 4);
            send_word(c);
            if (n == 90) drain();
        end
        drain();
    endtask

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        mismatches = 0;
        words_seen = 0;
        sent_items = 0;
        dispatches_seen = 0;
        burst_left = 0;
        table_reset();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_full_table();
        test_random();
        repeat (100) @(negedge clk);
        $display("%0d commands sent, %0d words checked, %0d dispatches, %0d mismatches",
                 sent_items, words_seen, dispatches_seen, mismatches);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

/* files.f */
sv/ptd_pkg.sv
sv/ptd_cell.sv
sv/priority_task_dispatcher_unit.sv
sv/ptd_checker.sv
test/tb.sv
